// File: design/pmpa_pkg.sv
// shared types, codes and constants of the page allocator
`timescale 1ns / 1ps
package pmpa_pkg;

  localparam int unsigned MaxRegionsDefault     = 8;
  localparam int unsigned PagesPerRegionDefault = 1024;
  localparam int unsigned AlignBits             = 16;
  localparam int unsigned AllocBits             = 14;
  localparam int unsigned AddrW                 = 64;

  localparam logic [6:0] PhysBitsReset = 7'd40;
  localparam logic [6:0] PhysBitsMin   = 7'd16;
  localparam logic [6:0] PhysBitsMax   = 7'd64;
  localparam logic [4:0] PageBitsReset = 5'd12;
  localparam logic [4:0] PageBitsMin   = 5'd10;
  localparam logic [4:0] PageBitsMax   = 5'd20;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DECODE = 2'd1,
    OP_ALLOC  = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNIMPL    = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_CONFLICT  = 3'd3,
    ST_BUS_MISS  = 3'd4,
    ST_NO_PAGE   = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    REG_PHYS_BITS = 1'b0,
    REG_PAGE_BITS = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,      // walk the region table
    S_ADD_CLR,   // clear the new region's bitmap
    S_ALLOC_PICK,// pick next region by base
    S_ALLOC_RD,  // issue bitmap read
    S_ALLOC_CHK, // check read data
    S_FREE_RD,
    S_FREE_WR,
    S_FINISH,
    S_OUT
  } state_t;

  function automatic logic [6:0] clamp_phys(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (v < PhysBitsMin) r = PhysBitsMin;
    if (v > PhysBitsMax) r = PhysBitsMax;
    return r;
  endfunction

  function automatic logic [4:0] clamp_page(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v < PageBitsMin) r = PageBitsMin;
    if (v > PageBitsMax) r = PageBitsMax;
    return r;
  endfunction

endpackage

// File: design/pmpa_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module pmpa_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: design/pmpa_cfg.sv
// apb register block for address bits and page size
`timescale 1ns / 1ps
module pmpa_cfg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready,
  output logic [6:0] phys_bits,
  output logic [4:0] page_bits
);
  import pmpa_pkg::*;

  logic [6:0] phys_r;
  logic [4:0] page_r;
  logic       wr;
  reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phys_r <= PhysBitsReset;
      page_r <= PageBitsReset;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (idx)
        REG_PHYS_BITS: phys_r <= clamp_phys(pwdata[6:0]);
        REG_PAGE_BITS: page_r <= clamp_page(pwdata[4:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_PHYS_BITS: prdata = {25'd0, phys_r};
      REG_PAGE_BITS: prdata = {27'd0, page_r};
      default: prdata = '0;
    endcase
  end

  assign phys_bits = phys_r;
  assign page_bits = page_r;
endmodule

// File: design/phys_memory_map_page_allocator_core.sv
// add walks the region table, then clears the new region's bitmap; decode walks
// the table; free walks it, then reads and writes one bitmap bit; allocate picks
// regions in order of base and reads their bitmap bits until a free page is found or none is left
// one item at a time, paced by the region table walk and the single bitmap ram port
// result held in an output register; next item accepted once it is taken
// synchronous active-low reset clears table valid bits, counters and config
`timescale 1ns / 1ps
module phys_memory_map_page_allocator_core #(
  parameter int unsigned MAX_REGIONS      = pmpa_pkg::MaxRegionsDefault,
  parameter int unsigned PAGES_PER_REGION = pmpa_pkg::PagesPerRegionDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,   // opcode[1:0], address[65:2], length[129:66],
                                   // region_offset[193:130], mem_flag[194], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // status[2:0], region_index[5:3],
                                   // result_address[69:6], zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import pmpa_pkg::*;

  localparam int unsigned RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned PW  = (PAGES_PER_REGION > 1) ? $clog2(PAGES_PER_REGION) : 1;
  localparam int unsigned CW  = $clog2(PAGES_PER_REGION + 1);
  localparam int unsigned RCW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned MD  = MAX_REGIONS * (2 ** PW);
  localparam int unsigned MW  = (MD > 1) ? $clog2(MD) : 1;

  logic [6:0] phys_bits;
  logic [4:0] page_bits;

  pmpa_cfg u_cfg (
    .clk, .rst_n,
    .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .phys_bits, .page_bits
  );

  // region table
  logic              valid_r [MAX_REGIONS];
  logic [AddrW-1:0]  base_r  [MAX_REGIONS];
  logic [AddrW-1:0]  size_r  [MAX_REGIONS];
  logic [AddrW-1:0]  offs_r  [MAX_REGIONS];
  logic [CW-1:0]     pcnt_r  [MAX_REGIONS];
  logic [AllocBits-1:0] alloc_cnt_r;

  // item registers
  op_t              op_r;
  logic [AddrW-1:0] addr_r, len_r, roffs_r;
  logic             mem_r;

  state_t state_r, state_nxt;
  logic [RCW-1:0] i_r;          // table walk index, can hold MAX_REGIONS
  logic [CW-1:0]  p_r;          // page index
  logic           have_r;       // a candidate found
  logic [RW-1:0]  best_r;
  logic           conf_r;       // overlap or equal base seen
  logic           slot_ok_r;
  logic [RW-1:0]  slot_r;
  logic           have_prev_r;
  logic [AddrW-1:0] prev_r;

  logic [2:0]       st_r;
  logic [2:0]       ridx_r;
  logic [AddrW-1:0] res_r;

  // bitmap ram
  logic          ram_we, ram_wd, ram_rd;
  logic [MW-1:0] ram_a;

  pmpa_ram #(.Width(1), .Depth(MD)) u_bitmap (
    .clk, .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd)
  );

  logic [RW-1:0] iw;
  assign iw = i_r[RW-1:0];

  // shared compare unit: one table entry per cycle
  logic [AddrW-1:0] e_b, e_end, n_end;
  logic             e_v;
  assign e_v   = valid_r[iw];
  assign e_b   = base_r[iw];
  assign e_end = base_r[iw] + size_r[iw];
  assign n_end = addr_r + len_r;

  logic overlap, scan_cand, pick_cand;
  assign overlap = (e_b >= addr_r && e_b < n_end) || (e_end > addr_r && e_end <= n_end) ||
                   (addr_r >= e_b && addr_r < e_end) || (n_end > e_b && n_end <= e_end) ||
                   (e_b == addr_r);
  assign scan_cand = e_v && (e_b <= addr_r) && (!have_r || e_b > base_r[best_r]);
  assign pick_cand = e_v && (!have_prev_r || e_b > prev_r) &&
                     (!have_r || e_b < base_r[best_r]);

  // add checks
  logic [AddrW-1:0] pmask;
  logic             unimpl, unalign, wrap;
  assign pmask   = (phys_bits >= 7'd64) ? '1 : ((AddrW'(1) << phys_bits[5:0]) - AddrW'(1));
  assign unimpl  = (addr_r & ~pmask) != '0;
  assign unalign = addr_r[AlignBits-1:0] != '0;
  assign wrap    = n_end < addr_r;

  // decode and free range check, exact 65-bit sum
  logic [AddrW:0]   sum65, end65;
  logic [AddrW-1:0] rel;
  logic [AddrW-1:0] pn;
  assign sum65 = {1'b0, addr_r} + {1'b0, len_r};
  assign end65 = {1'b0, base_r[best_r]} + {1'b0, size_r[best_r]};
  assign rel   = addr_r - base_r[best_r];
  assign pn    = rel >> page_bits;
  logic hit;
  assign hit = have_r && (sum65 <= end65);
  logic pn_ok;
  assign pn_ok = (pn < AddrW'(pcnt_r[best_r])) && (pn < AddrW'(PAGES_PER_REGION));

  logic [CW-1:0] page_lim;
  assign page_lim = pcnt_r[best_r];

  logic [AddrW-1:0] pages_raw;
  logic [CW-1:0]    pages_sat;
  assign pages_raw = len_r >> page_bits;
  assign pages_sat = !mem_r ? '0 :
                     (pages_raw > AddrW'(PAGES_PER_REGION)) ? CW'(PAGES_PER_REGION)
                                                            : pages_raw[CW-1:0];

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = (op_t'(in_tdata[1:0]) == OP_ALLOC) ? S_ALLOC_PICK : S_SCAN;
      S_SCAN: begin
        if (i_r == RCW'(MAX_REGIONS - 1)) begin
          if (op_r == OP_ADD) begin
            state_nxt = (unimpl || unalign || wrap || conf_r || overlap && e_v ||
                         !(slot_ok_r || !e_v)) ? S_FINISH : S_ADD_CLR;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_ADD_CLR: if (p_r == CW'(PAGES_PER_REGION - 1)) state_nxt = S_FINISH;
      S_ALLOC_PICK: begin
        if (i_r == RCW'(MAX_REGIONS - 1)) begin
          if (!(have_r || pick_cand)) state_nxt = S_FINISH;
          else state_nxt = S_ALLOC_RD;
        end
      end
      S_ALLOC_RD: state_nxt = (p_r < page_lim && p_r < CW'(PAGES_PER_REGION)) ? S_ALLOC_CHK
                                                                              : S_ALLOC_PICK;
      S_ALLOC_CHK: state_nxt = ram_rd ? S_ALLOC_RD : S_FINISH;
      S_FREE_RD: state_nxt = S_FREE_WR;
      S_FREE_WR: state_nxt = S_OUT;
      S_FINISH: begin
        if (op_r == OP_FREE && hit && pn_ok) state_nxt = S_FREE_RD;
        else state_nxt = S_OUT;
      end
      S_OUT: if (out_acc) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    ram_we = 1'b0;
    ram_wd = 1'b0;
    ram_a  = MW'({best_r, p_r[PW-1:0]});
    case (state_r)
      S_ADD_CLR: begin
        ram_we = 1'b1;
        ram_a  = MW'({slot_r, p_r[PW-1:0]});
      end
      S_FREE_RD: ram_a = MW'({best_r, pn[PW-1:0]});
      S_FREE_WR: begin
        ram_we = 1'b1;
        ram_a  = MW'({best_r, pn[PW-1:0]});
      end
      S_ALLOC_CHK: begin
        ram_we = !ram_rd;
        ram_wd = 1'b1;
        ram_a  = MW'({best_r, p_r[PW-1:0]});
      end
      default: ;
    endcase
  end

  assign out_tdata = {2'b00, res_r, ridx_r, st_r};

  logic last_found;
  assign last_found = have_r || pick_cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alloc_cnt_r <= '0;
      for (int k = 0; k < MAX_REGIONS; k++) begin
        valid_r[k] <= 1'b0;
        pcnt_r[k]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_acc) begin
          op_r        <= op_t'(in_tdata[1:0]);
          addr_r      <= in_tdata[65:2];
          len_r       <= in_tdata[129:66];
          roffs_r     <= in_tdata[193:130];
          mem_r       <= in_tdata[194];
          i_r         <= '0;
          p_r         <= '0;
          have_r      <= 1'b0;
          best_r      <= '0;
          conf_r      <= 1'b0;
          slot_ok_r   <= 1'b0;
          have_prev_r <= 1'b0;
          st_r        <= ST_OK;
          ridx_r      <= '0;
          res_r       <= '0;
        end
        S_SCAN: begin
          i_r <= i_r + 1'b1;
          if (scan_cand) begin
            have_r <= 1'b1;
            best_r <= iw;
          end
          if (e_v && overlap) conf_r <= 1'b1;
          if (!e_v && !slot_ok_r) begin
            slot_ok_r <= 1'b1;
            slot_r    <= iw;
          end
          if (op_r == OP_ADD && i_r == RCW'(MAX_REGIONS - 1)) begin
            if (unimpl) st_r <= ST_UNIMPL;
            else if (unalign) st_r <= ST_UNALIGNED;
            else if (wrap || conf_r || (e_v && overlap) || !(slot_ok_r || !e_v))
              st_r <= ST_CONFLICT;
            else begin
              valid_r[slot_ok_r ? slot_r : iw] <= 1'b1;
              base_r[slot_ok_r ? slot_r : iw]  <= addr_r;
              size_r[slot_ok_r ? slot_r : iw]  <= len_r;
              offs_r[slot_ok_r ? slot_r : iw]  <= roffs_r;
              pcnt_r[slot_ok_r ? slot_r : iw]  <= pages_sat;
              ridx_r <= 3'(slot_ok_r ? slot_r : iw);
            end
          end
        end
        S_ADD_CLR: p_r <= p_r + 1'b1;
        S_ALLOC_PICK: begin
          i_r <= i_r + 1'b1;
          if (pick_cand) begin
            have_r <= 1'b1;
            best_r <= iw;
          end
          if (i_r == RCW'(MAX_REGIONS - 1)) begin
            p_r <= '0;
            if (last_found) begin
              have_prev_r <= 1'b1;
              prev_r      <= pick_cand ? e_b : base_r[best_r];
            end else begin
              st_r <= ST_NO_PAGE;
            end
          end
        end
        S_ALLOC_RD: begin
          if (!(p_r < page_lim && p_r < CW'(PAGES_PER_REGION))) begin
            i_r    <= '0;
            have_r <= 1'b0;
          end
        end
        S_ALLOC_CHK: begin
          p_r <= p_r + 1'b1;
          if (!ram_rd) begin
            alloc_cnt_r <= alloc_cnt_r + 1'b1;
            ridx_r      <= 3'(best_r);
            res_r       <= base_r[best_r] + (AddrW'(p_r) << page_bits);
          end
        end
        S_FINISH: begin
          if (op_r == OP_DECODE) begin
            if (hit) begin
              ridx_r <= 3'(best_r);
              res_r  <= addr_r - base_r[best_r] + offs_r[best_r];
            end else st_r <= ST_BUS_MISS;
          end else if (op_r == OP_FREE) begin
            if (hit && pn_ok) ridx_r <= 3'(best_r);
            else st_r <= ST_BUS_MISS;
          end
        end
        S_FREE_WR: if (ram_rd) alloc_cnt_r <= alloc_cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != ST_OK |-> out_tdata[69:3] == '0)
    else $error("failure with nonzero index or address");
`endif
endmodule
